### rtl/psgvgm_pkg.sv
// shared constants, codes and types of the psg to vgm command transcoder
package psgvgm_pkg;

   // psg stream command bytes
   localparam logic [7:0] PSG_FRAME_WAIT = 8'hFF;
   localparam logic [7:0] PSG_LONG_WAIT  = 8'hFE;

   // vgm command bytes
   localparam logic [7:0] VGM_WAIT_N     = 8'h61;
   localparam logic [7:0] VGM_WAIT_FRAME = 8'h63;
   localparam logic [7:0] VGM_PSG_WRITE  = 8'hA0;
   localparam logic [7:0] VGM_END        = 8'h66;
   localparam logic [7:0] VGM_FULL_BYTE  = 8'hFF;

   // header layout
   localparam logic [4:0] HDR_LEN       = 5'd16;
   localparam logic [4:0] HDR_MAGIC_LEN = 5'd4;

   // largest wait that one 0x61 chunk carries
   localparam logic [19:0] CHUNK_MAX = 20'h0FFFF;

   // configuration registers
   localparam logic [9:0] FRAME_SAMPLES_RST = 10'd882;
   localparam logic       REG_FRAME_SAMPLES = 1'b0;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_CMD,
      PH_COUNT,
      PH_VALUE
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EOS,
      ST_FRAME,
      ST_REG_CMD,
      ST_REG_NUM,
      ST_VALUE,
      ST_MUL,
      ST_ADD,
      ST_CHUNK_CMD,
      ST_CHUNK_LO,
      ST_CHUNK_HI
   } seq_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'h50;
         2'd1:    b = 8'h53;
         2'd2:    b = 8'h47;
         default: b = 8'h1A;
      endcase
      return b;
   endfunction

endpackage

### rtl/psgvgm_if.sv
// valid/ready channel interfaces for psg input bytes and vgm output bytes
interface psgvgm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface psgvgm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last;
   logic [31:0] sample_total;
   logic        header_error;

   modport source (output valid, output out_byte, output last, output sample_total,
                   output header_error, input ready);
   modport sink   (input valid, input out_byte, input last, input sample_total,
                   input header_error, output ready);
endinterface

### rtl/psg_to_vgm_command_transcoder_core.sv
// top level of the psg register dump to vgm command byte transcoder
//
// Takes one psg stream byte per req beat and sends the vgm command bytes that
// it completes on rsp, one byte per beat, with last on the final byte of each
// input. The first 16 bytes are the header (magic 'P','S','G',0x1A checked,
// a mismatch sets the sticky header_error); they give no rsp beats. After the
// header: 0xFF gives 0x63, 0xFE plus a count byte gives a long wait of
// count*4*frame_samples emitted as 0x61 FF FF chunks and a closing 0x61 lo hi
// chunk, any other byte plus a value byte gives 0xA0 reg value. An
// end_of_stream beat always gives one 0x66 beat. sample_total and
// header_error on rsp are the values after the input that caused the beat,
// captured into the rsp output register along with the byte.
// Sequencing: header bytes and the 0xFE of a long wait only update the parse
// state; every other byte is followed by its emitted bytes, one per beat
// while rsp is ready. A long wait's count byte first runs 8 shift-add steps
// of the shared 20-bit adder (one per bit of the count), then an add into
// the sample total, then up to 16 chunks of three bytes. The block takes
// no new byte until the last byte of the current one is loaded into the rsp
// output register. frame_samples is written through the apb-style port at
// byte address 0, by the user only while idle; the block does not enforce it.
module psg_to_vgm_command_transcoder_core
   import psgvgm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   psgvgm_req_if.sink         req,
   psgvgm_rsp_if.source       rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // sequencer and parse state
   seq_type     state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [4:0]  hdr_cnt_ff, hdr_cnt_in;
   logic        bad_ff, bad_in;
   logic [31:0] total_ff, total_in;
   logic [9:0]  fs_ff, fs_in;

   // working registers of the current item
   logic [7:0]  hold_ff, hold_in;
   logic [19:0] wait_ff, wait_in;
   logic [2:0]  mul_cnt_ff, mul_cnt_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_total_ff, rsp_total_in;
   logic        rsp_herr_ff, rsp_herr_in;

   // handshake terms
   logic        req_fire;
   logic        slot_free;
   logic        emit_req;
   logic        emit_fire;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic        csr_write;

   // shared 20-bit adder: shift-add multiply steps and the chunk compare
   logic [19:0] alu_a;
   logic [19:0] alu_b;
   logic        alu_cin;
   logic [20:0] alu_sum;
   logic        chunk_full;

   // sample total adder
   logic [31:0] tot_add;

   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign emit_fire = emit_req && slot_free;
   assign csr_write = psel && penable && pwrite && pready;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_FRAME_SAMPLES) ? {22'd0, fs_ff} : 32'd0;

   // shared unit operand select: multiply step in ST_MUL, else wait - 0xFFFF
   always_comb begin
      if (state_ff == ST_MUL) begin
         alu_a   = {wait_ff[18:0], 1'b0};
         alu_b   = hold_ff[7] ? {8'd0, fs_ff, 2'b00} : 20'd0;
         alu_cin = 1'b0;
      end else begin
         alu_a   = wait_ff;
         alu_b   = ~CHUNK_MAX;
         alu_cin = 1'b1;
      end
   end

   assign alu_sum    = {1'b0, alu_a} + {1'b0, alu_b} + {20'd0, alu_cin};
   // carry out of the subtract means a full 0xFFFF chunk remains
   assign chunk_full = alu_sum[20];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.end_of_stream) begin
                  state_in = ST_EOS;
               end else begin
                  unique case (phase_ff)
                     PH_HEADER: state_in = ST_IDLE;
                     PH_CMD: begin
                        priority if (req.in_byte == PSG_FRAME_WAIT) begin
                           state_in = ST_FRAME;
                        end else if (req.in_byte == PSG_LONG_WAIT) begin
                           state_in = ST_IDLE;
                        end else begin
                           state_in = ST_REG_CMD;
                        end
                     end
                     PH_COUNT: state_in = ST_MUL;
                     PH_VALUE: state_in = ST_VALUE;
                  endcase
               end
            end
         end
         ST_EOS, ST_FRAME, ST_REG_NUM, ST_VALUE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_REG_CMD: begin
            if (slot_free) state_in = ST_REG_NUM;
         end
         ST_MUL: begin
            if (mul_cnt_ff == 3'd7) state_in = ST_ADD;
         end
         ST_ADD: state_in = ST_CHUNK_CMD;
         ST_CHUNK_CMD: begin
            if (slot_free) state_in = ST_CHUNK_LO;
         end
         ST_CHUNK_LO: begin
            if (slot_free) state_in = ST_CHUNK_HI;
         end
         ST_CHUNK_HI: begin
            if (slot_free) state_in = chunk_full ? ST_CHUNK_CMD : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req.ready = 1'b0;
      emit_req  = 1'b0;
      emit_byte = 8'd0;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         ST_EOS: begin
            emit_req  = 1'b1;
            emit_byte = VGM_END;
            emit_last = 1'b1;
         end
         ST_FRAME: begin
            emit_req  = 1'b1;
            emit_byte = VGM_WAIT_FRAME;
            emit_last = 1'b1;
         end
         ST_REG_CMD: begin
            emit_req  = 1'b1;
            emit_byte = VGM_PSG_WRITE;
         end
         ST_REG_NUM, ST_VALUE: begin
            emit_req  = 1'b1;
            emit_byte = hold_ff;
            emit_last = 1'b1;
         end
         ST_MUL, ST_ADD: begin
            emit_req = 1'b0;
         end
         ST_CHUNK_CMD: begin
            emit_req  = 1'b1;
            emit_byte = VGM_WAIT_N;
         end
         ST_CHUNK_LO: begin
            emit_req  = 1'b1;
            emit_byte = chunk_full ? VGM_FULL_BYTE : wait_ff[7:0];
         end
         ST_CHUNK_HI: begin
            emit_req  = 1'b1;
            emit_byte = chunk_full ? VGM_FULL_BYTE : wait_ff[15:8];
            emit_last = !chunk_full;
         end
         default: req.ready = 1'b0;
      endcase
   end

   // sample total addend: one frame on a frame wait, the product on a long wait
   always_comb begin
      if (state_ff == ST_ADD) begin
         tot_add = {12'd0, wait_ff};
      end else begin
         tot_add = {22'd0, fs_ff};
      end
   end

   // datapath next values
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      bad_in     = bad_ff;
      total_in   = total_ff;
      fs_in      = fs_ff;
      hold_in    = hold_ff;
      wait_in    = wait_ff;
      mul_cnt_in = mul_cnt_ff;

      if (csr_write && (paddr[2] == REG_FRAME_SAMPLES)) begin
         fs_in = pwdata[9:0];
      end

      if (req_fire) begin
         if (req.end_of_stream) begin
            // a pending count or value byte is dropped
            if (phase_ff != PH_HEADER) phase_in = PH_CMD;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if ((hdr_cnt_ff < HDR_MAGIC_LEN) &&
                      (req.in_byte != magic_byte(hdr_cnt_ff[1:0]))) begin
                     bad_in = 1'b1;
                  end
                  hdr_cnt_in = hdr_cnt_ff + 5'd1;
                  if (hdr_cnt_in >= HDR_LEN) phase_in = PH_CMD;
               end
               PH_CMD: begin
                  priority if (req.in_byte == PSG_FRAME_WAIT) begin
                     total_in = total_ff + tot_add;
                  end else if (req.in_byte == PSG_LONG_WAIT) begin
                     phase_in = PH_COUNT;
                  end else begin
                     hold_in  = req.in_byte;
                     phase_in = PH_VALUE;
                  end
               end
               PH_COUNT: begin
                  // count byte is shifted out msb first by the multiply steps
                  hold_in    = req.in_byte;
                  wait_in    = 20'd0;
                  mul_cnt_in = 3'd0;
                  phase_in   = PH_CMD;
               end
               PH_VALUE: begin
                  hold_in  = req.in_byte;
                  phase_in = PH_CMD;
               end
            endcase
         end
      end

      unique case (state_ff)
         ST_MUL: begin
            wait_in    = alu_sum[19:0];
            hold_in    = {hold_ff[6:0], 1'b0};
            mul_cnt_in = mul_cnt_ff + 3'd1;
         end
         ST_ADD: total_in = total_ff + tot_add;
         ST_CHUNK_HI: begin
            // step down by one full chunk, or clear after the closing chunk
            if (slot_free) wait_in = chunk_full ? alu_sum[19:0] : 20'd0;
         end
         default: begin
         end
      endcase
   end

   // output register: loads on an emitted byte with the totals it reports,
   // empties when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_total_in = rsp_total_ff;
      rsp_herr_in  = rsp_herr_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_total_in = total_ff;
         rsp_herr_in  = bad_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= 5'd0;
         bad_ff       <= 1'b0;
         total_ff     <= 32'd0;
         fs_ff        <= FRAME_SAMPLES_RST;
         wait_ff      <= 20'd0;
         mul_cnt_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         bad_ff       <= bad_in;
         total_ff     <= total_in;
         fs_ff        <= fs_in;
         wait_ff      <= wait_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
      rsp_herr_ff  <= rsp_herr_in;
   end

   // totals travel with the beat, so a waiting beat keeps its own values
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_byte     = rsp_byte_ff;
   assign rsp.last         = rsp_last_ff;
   assign rsp.sample_total = rsp_total_ff;
   assign rsp.header_error = rsp_herr_ff;

endmodule
